### hdl/mck_pkg.sv
// Shared types, constants and the character code table for the Morse keyer.
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_DOT_ON    = 3'd0,
        REG_DASH_ON   = 3'd1,
        REG_DOT_OFF   = 3'd2,
        REG_DASH_OFF  = 3'd3,
        REG_REST      = 3'd4,
        REG_SPEED     = 3'd5
    } reg_idx_t;

    localparam int CHAR_W   = 8;
    localparam int TIME_W   = 12;
    localparam int SPEED_W  = 8;
    localparam int PHASE_W  = 14;
    localparam int PROD_W   = TIME_W + SPEED_W;
    localparam int MAX_SYMS = 6;
    localparam int LEN_W    = 3;
    localparam int RESTS_W  = 2;

    localparam logic [TIME_W-1:0]  DOT_ON_RST   = 12'd120;
    localparam logic [TIME_W-1:0]  DASH_ON_RST  = 12'd300;
    localparam logic [TIME_W-1:0]  DOT_OFF_RST  = 12'd80;
    localparam logic [TIME_W-1:0]  DASH_OFF_RST = 12'd80;
    localparam logic [TIME_W-1:0]  REST_RST     = 12'd320;
    localparam logic [SPEED_W-1:0] SPEED_RST    = 8'd120;

    // x / 100 == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2**20.
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP_W     = 21;
    localparam int QUOT_FULL_W = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 21'd1342178;

    // One character: symbol count, dash flags (first symbol in bit 0) and rests.
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [MAX_SYMS-1:0] dash;
        logic [RESTS_W-1:0]  rests;
    } desc_t;

    function automatic desc_t classify(input logic [CHAR_W-1:0] c);
        desc_t             d;
        logic [CHAR_W-1:0] lc;
        logic [CHAR_W-1:0] off;
        d.len   = 3'd0;
        d.dash  = 6'b000000;
        d.rests = 2'd1;
        lc      = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
        if (lc >= 8'h61 && lc <= 8'h7A) begin
            off = lc - 8'h61;
            case (off[4:0])
                5'd0:    begin d.len = 3'd2; d.dash = 6'b000010; end
                5'd1:    begin d.len = 3'd4; d.dash = 6'b000001; end
                5'd2:    begin d.len = 3'd4; d.dash = 6'b000101; end
                5'd3:    begin d.len = 3'd3; d.dash = 6'b000001; end
                5'd4:    begin d.len = 3'd1; d.dash = 6'b000000; end
                5'd5:    begin d.len = 3'd4; d.dash = 6'b000100; end
                5'd6:    begin d.len = 3'd3; d.dash = 6'b000011; end
                5'd7:    begin d.len = 3'd4; d.dash = 6'b000000; end
                5'd8:    begin d.len = 3'd2; d.dash = 6'b000000; end
                5'd9:    begin d.len = 3'd4; d.dash = 6'b001110; end
                5'd10:   begin d.len = 3'd3; d.dash = 6'b000101; end
                5'd11:   begin d.len = 3'd4; d.dash = 6'b000010; end
                5'd12:   begin d.len = 3'd2; d.dash = 6'b000011; end
                5'd13:   begin d.len = 3'd2; d.dash = 6'b000001; end
                5'd14:   begin d.len = 3'd3; d.dash = 6'b000111; end
                5'd15:   begin d.len = 3'd4; d.dash = 6'b000110; end
                5'd16:   begin d.len = 3'd4; d.dash = 6'b001011; end
                5'd17:   begin d.len = 3'd3; d.dash = 6'b000010; end
                5'd18:   begin d.len = 3'd3; d.dash = 6'b000000; end
                5'd19:   begin d.len = 3'd1; d.dash = 6'b000001; end
                5'd20:   begin d.len = 3'd3; d.dash = 6'b000100; end
                5'd21:   begin d.len = 3'd4; d.dash = 6'b001000; end
                5'd22:   begin d.len = 3'd3; d.dash = 6'b000110; end
                5'd23:   begin d.len = 3'd4; d.dash = 6'b001001; end
                5'd24:   begin d.len = 3'd4; d.dash = 6'b001101; end
                5'd25:   begin d.len = 3'd4; d.dash = 6'b000011; end
                default: begin d.len = 3'd0; d.dash = 6'b000000; end
            endcase
        end else if (c >= 8'h30 && c <= 8'h39) begin
            off   = c - 8'h30;
            d.len = 3'd5;
            case (off[3:0])
                4'd0:    d.dash = 6'b011111;
                4'd1:    d.dash = 6'b011110;
                4'd2:    d.dash = 6'b011100;
                4'd3:    d.dash = 6'b011000;
                4'd4:    d.dash = 6'b010000;
                4'd5:    d.dash = 6'b000000;
                4'd6:    d.dash = 6'b000001;
                4'd7:    d.dash = 6'b000011;
                4'd8:    d.dash = 6'b000111;
                4'd9:    d.dash = 6'b001111;
                default: d.dash = 6'b000000;
            endcase
        end else if (c == 8'h2E) begin
            d.len   = 3'd6;
            d.dash  = 6'b101010;
            d.rests = 2'd3;
        end else if (c == 8'h20 || c == 8'h0A) begin
            d.rests = 2'd3;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### hdl/morse_code_keyer_core.sv
// Top level of the Morse keyer: character requests in, timed keying phases out.
//
//  Channel   Direction  Payload                                  Handshake
//  s_*       in         tdata[7:0] char_code                     tvalid/tready
//  m_*       out        tdata[0] key_level, [14:1] phase_ms,     tvalid/tready
//                       tlast last_phase
//  cfg_*     in         cfg_index register, cfg_data value       cfg_we
//
// The sequencer issues one phase a cycle unless the output stalls; a character has
// 1 to 15 phases. An issued phase passes the product register (multiply) and then
// the output register (divide by 100) before it reaches the output.
// Reset loads the default timing values and empties the queue and pipeline.
// A two-entry queue accepts up to two requests while the output side stalls.
`timescale 1ns / 1ps
`default_nettype none

module morse_code_keyer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] char_code
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,   // [0] key_level, [14:1] phase_ms
    output logic                               m_tlast,   // last_phase
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [mck_pkg::TIME_W-1:0]    cfg_data
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    mck_pkg::desc_t q_desc;
    mck_pkg::desc_t q_head;

    mck_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (q_desc)
    );

    mck_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_desc),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    mck_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

### hdl/mck_front.sv
// Front end: takes character requests and turns each into a keying descriptor.
`timescale 1ns / 1ps
`default_nettype none

module mck_front (
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [mck_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] char_code
    input  wire logic                        q_full,
    output logic                             q_push,
    output mck_pkg::desc_t                   q_desc
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_desc   = mck_pkg::classify(s_tdata);

endmodule

`default_nettype wire

### hdl/mck_queue.sv
// Two-entry descriptor queue between the front end and the phase sequencer.
`timescale 1ns / 1ps
`default_nettype none

module mck_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mck_pkg::desc_t push_desc,
    input  wire logic           pop,
    output logic                full,
    output logic                valid,
    output mck_pkg::desc_t      head
);

    mck_pkg::desc_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

### hdl/mck_back.sv
// Back end: timing registers, phase sequencer and the duration scaling pipeline.
`timescale 1ns / 1ps
`default_nettype none

module mck_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [mck_pkg::TIME_W-1:0]    cfg_data,
    input  wire logic                          q_valid,
    input  wire mck_pkg::desc_t                q_head,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,   // [0] key_level, [14:1] phase_ms
    output logic                               m_tlast    // last_phase
);

    logic [mck_pkg::TIME_W-1:0]  dot_on_reg;
    logic [mck_pkg::TIME_W-1:0]  dash_on_reg;
    logic [mck_pkg::TIME_W-1:0]  dot_off_reg;
    logic [mck_pkg::TIME_W-1:0]  dash_off_reg;
    logic [mck_pkg::TIME_W-1:0]  rest_reg;
    logic [mck_pkg::SPEED_W-1:0] speed_reg;

    // Sequencer state.
    logic                         busy_reg;
    logic                         busy_next;
    mck_pkg::desc_t               cur_reg;
    mck_pkg::desc_t               cur_next;
    logic [mck_pkg::LEN_W-1:0]    sym_reg;
    logic [mck_pkg::LEN_W-1:0]    sym_next;
    logic                         gap_reg;
    logic                         gap_next;
    logic [mck_pkg::RESTS_W-1:0]  rests_reg;
    logic [mck_pkg::RESTS_W-1:0]  rests_next;

    // Pipeline: product stage, then the output register.
    logic                          s1_valid_reg;
    logic                          s1_level_reg;
    logic                          s1_last_reg;
    logic [mck_pkg::PROD_W-1:0]    s1_prod_reg;
    logic                          out_valid_reg;
    logic                          out_level_reg;
    logic                          out_last_reg;
    logic [mck_pkg::PHASE_W-1:0]   out_phase_reg;

    logic                          adv;
    logic                          issue;
    logic                          load;
    logic                          in_syms;
    logic                          is_dash;
    logic                          ph_level;
    logic                          ph_last;
    logic [mck_pkg::TIME_W-1:0]    ph_base;
    logic [mck_pkg::PROD_W-1:0]    ph_prod;
    logic [mck_pkg::QUOT_FULL_W-1:0] quot_full;

    assign adv   = !out_valid_reg || m_tready;
    assign issue = adv && busy_reg;

    always_comb
    begin
        in_syms  = (sym_reg < cur_reg.len);
        is_dash  = in_syms && cur_reg.dash[sym_reg];
        ph_level = in_syms && !gap_reg;
        ph_last  = !in_syms && (rests_reg == 2'd1);
        if (!in_syms)
        begin
            ph_base = rest_reg;
        end
        else if (gap_reg)
        begin
            ph_base = is_dash ? dash_off_reg : dot_off_reg;
        end
        else
        begin
            ph_base = is_dash ? dash_on_reg : dot_on_reg;
        end
        ph_prod   = mck_pkg::PROD_W'(ph_base) * mck_pkg::PROD_W'(speed_reg);
        quot_full = mck_pkg::QUOT_FULL_W'(s1_prod_reg)
                  * mck_pkg::QUOT_FULL_W'(mck_pkg::RECIP_MUL);
    end

    // If not stalled, a descriptor loads when idle or in the cycle the last phase issues.
    assign load  = adv && q_valid && (!busy_reg || (issue && ph_last));
    assign q_pop = load;

    always_comb
    begin
        busy_next  = busy_reg;
        cur_next   = cur_reg;
        sym_next   = sym_reg;
        gap_next   = gap_reg;
        rests_next = rests_reg;
        if (issue)
        begin
            if (in_syms)
            begin
                gap_next = !gap_reg;
                if (gap_reg)
                begin
                    sym_next = sym_reg + 3'd1;
                end
            end
            else
            begin
                rests_next = rests_reg - 2'd1;
                if (ph_last)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        if (load)
        begin
            busy_next  = 1'b1;
            cur_next   = q_head;
            sym_next   = '0;
            gap_next   = 1'b0;
            rests_next = q_head.rests;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_on_reg   <= mck_pkg::DOT_ON_RST;
            dash_on_reg  <= mck_pkg::DASH_ON_RST;
            dot_off_reg  <= mck_pkg::DOT_OFF_RST;
            dash_off_reg <= mck_pkg::DASH_OFF_RST;
            rest_reg     <= mck_pkg::REST_RST;
            speed_reg    <= mck_pkg::SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mck_pkg::REG_DOT_ON:   dot_on_reg   <= cfg_data;
                mck_pkg::REG_DASH_ON:  dash_on_reg  <= cfg_data;
                mck_pkg::REG_DOT_OFF:  dot_off_reg  <= cfg_data;
                mck_pkg::REG_DASH_OFF: dash_off_reg <= cfg_data;
                mck_pkg::REG_REST:     rest_reg     <= cfg_data;
                mck_pkg::REG_SPEED:    speed_reg    <= cfg_data[mck_pkg::SPEED_W-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        sym_reg   <= sym_next;
        gap_reg   <= gap_next;
        rests_reg <= rests_next;
        if (adv)
        begin
            s1_level_reg  <= ph_level;
            s1_last_reg   <= ph_last;
            s1_prod_reg   <= ph_prod;
            out_level_reg <= s1_level_reg;
            out_last_reg  <= s1_last_reg;
            out_phase_reg <= quot_full[mck_pkg::RECIP_SHIFT +: mck_pkg::PHASE_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_phase_reg, out_level_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
